>>> design/tle_pkg.sv
// Shared constants, types and helpers of the terminal line editor.
`default_nettype none
package tle_pkg;

    // Line store geometry and per-byte result bound
    localparam int LINE_DEPTH  = 64;
    localparam int MAX_RESULTS = 42;
    localparam int LIM_CAP     = (LINE_DEPTH < MAX_RESULTS - 2) ? LINE_DEPTH : MAX_RESULTS - 2;
    localparam int ADDR_W      = $clog2(LINE_DEPTH);
    localparam int CUR_W       = $clog2(LIM_CAP + 1);

    // Configuration register
    localparam int           LIMIT_W     = 7;
    localparam logic [6:0]   LIMIT_RESET = 7'd40;

    // Keyboard codes
    localparam logic [7:0] KEY_EOF       = 8'd4;
    localparam logic [7:0] KEY_NEWLINE   = 8'd10;
    localparam logic [7:0] KEY_KILL_LINE = 8'd21;
    localparam logic [7:0] KEY_KILL_WORD = 8'd23;
    localparam logic [7:0] KEY_SPACE     = 8'd32;
    localparam logic [7:0] KEY_TILDE     = 8'd126;
    localparam logic [7:0] KEY_DELETE    = 8'd127;

    typedef enum logic [2:0] {
        ACT_ECHO    = 3'd0,
        ACT_ERASE   = 3'd1,
        ACT_BELL    = 3'd2,
        ACT_LINE    = 3'd3,
        ACT_END     = 3'd4,
        ACT_SESSION = 3'd5
    } t_action;

    typedef struct packed {
        t_action    act;
        logic [7:0] data;
        logic       last;
    } t_result;

    typedef struct packed {
        logic    valid;
        t_result res;
    } t_push;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_WORD,
        S_SPACE,
        S_CHECK,
        S_FLUSH,
        S_END,
        S_FIN
    } t_state;

    // Clamp the programmed limit to 1..LIM_CAP
    function automatic logic [CUR_W-1:0] eff_limit(input logic [LIMIT_W-1:0] raw);
        logic [CUR_W-1:0] lim;
        if (raw == '0) begin
            lim = CUR_W'(1);
        end else if (raw > LIMIT_W'(LIM_CAP)) begin
            lim = CUR_W'(LIM_CAP);
        end else begin
            lim = CUR_W'(raw);
        end
        return lim;
    endfunction

endpackage
`default_nettype wire

>>> design/tle_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none
module tle_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

>>> design/tle_seq.sv
// Editing sequencer: walks the line store and produces results one at a time.
`default_nettype none
module tle_seq import tle_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_in_byte,
    input  wire logic [LIMIT_W-1:0] i_line_limit,
    input  wire logic               i_out_ready,
    output t_push                   o_push
);

    t_state           r_state, n_state;
    logic [CUR_W-1:0] r_cursor, n_cursor;
    logic [CUR_W-1:0] r_fidx, n_fidx;
    logic             r_session_over, n_session_over;
    logic [7:0]       r_byte;
    logic             r_pend_valid;
    t_action          r_pend_act;
    logic [7:0]       r_pend_data;

    logic             go;
    logic             emit;
    t_action          emit_act;
    logic [7:0]       emit_data;
    logic             fin;
    logic             wr_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic [CUR_W-1:0] lim;
    logic             eof_empty;
    logic             printable;
    logic             flush_now;
    logic             flush_done;

    assign lim        = eff_limit(i_line_limit);
    assign go         = !r_pend_valid || i_out_ready;
    assign eof_empty  = (r_byte == KEY_EOF) && (r_cursor == '0);
    assign printable  = (r_byte >= KEY_SPACE) && (r_byte <= KEY_TILDE);
    assign flush_now  = (r_cursor >= lim) || (r_byte == KEY_NEWLINE);
    assign flush_done = (CUR_W'(r_fidx + CUR_W'(1)) == r_cursor);
    assign o_in_stall = (r_state != S_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_session_over) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (go) begin
                    priority if (eof_empty) begin
                        n_state = S_FIN;
                    end else if (r_byte == KEY_KILL_WORD) begin
                        n_state = S_WORD;
                    end else if (r_byte == KEY_KILL_LINE) begin
                        if (r_cursor == '0) n_state = S_CHECK;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_WORD: begin
                if (go && !(r_cursor != '0 && rd_data != KEY_SPACE)) n_state = S_SPACE;
            end
            S_SPACE: begin
                if (go && !(r_cursor != '0 && rd_data == KEY_SPACE)) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (go) begin
                    if (!flush_now) begin
                        n_state = S_FIN;
                    end else if (r_cursor == '0) begin
                        n_state = S_END;
                    end else begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (go && flush_done) n_state = S_END;
            end
            S_END: begin
                if (go) n_state = S_FIN;
            end
            S_FIN: begin
                if (go) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Results, cursor moves and store writes
    always_comb begin
        emit           = 1'b0;
        emit_act       = ACT_BELL;
        emit_data      = 8'd0;
        fin            = 1'b0;
        wr_en          = 1'b0;
        n_cursor       = r_cursor;
        n_fidx         = r_fidx;
        n_session_over = r_session_over;
        unique case (r_state)
            S_IDLE: begin
            end
            S_DECIDE: begin
                if (go) begin
                    priority if (eof_empty) begin
                        emit           = 1'b1;
                        emit_act       = ACT_SESSION;
                        n_session_over = 1'b1;
                    end else if (r_byte == KEY_KILL_WORD) begin
                    end else if (r_byte == KEY_DELETE || r_byte == KEY_KILL_LINE) begin
                        if (r_cursor != '0) begin
                            emit     = 1'b1;
                            emit_act = ACT_ERASE;
                            n_cursor = CUR_W'(r_cursor - CUR_W'(1));
                        end
                    end else if (printable) begin
                        if (r_cursor < lim) begin
                            wr_en     = 1'b1;
                            emit      = 1'b1;
                            emit_act  = ACT_ECHO;
                            emit_data = r_byte;
                            n_cursor  = CUR_W'(r_cursor + CUR_W'(1));
                        end
                    end else begin
                        emit     = 1'b1;
                        emit_act = ACT_BELL;
                    end
                end
            end
            S_WORD: begin
                if (go && r_cursor != '0 && rd_data != KEY_SPACE) begin
                    emit     = 1'b1;
                    emit_act = ACT_ERASE;
                    n_cursor = CUR_W'(r_cursor - CUR_W'(1));
                end
            end
            S_SPACE: begin
                if (go && r_cursor != '0 && rd_data == KEY_SPACE) begin
                    emit     = 1'b1;
                    emit_act = ACT_ERASE;
                    n_cursor = CUR_W'(r_cursor - CUR_W'(1));
                end
            end
            S_CHECK: begin
                if (go) n_fidx = '0;
            end
            S_FLUSH: begin
                if (go) begin
                    emit      = 1'b1;
                    emit_act  = ACT_LINE;
                    emit_data = rd_data;
                    n_fidx    = CUR_W'(r_fidx + CUR_W'(1));
                end
            end
            S_END: begin
                if (go) begin
                    emit     = 1'b1;
                    emit_act = ACT_END;
                    n_cursor = '0;
                end
            end
            S_FIN: begin
                fin = go;
            end
            default: begin
            end
        endcase
    end

    // Read the entry the next state will look at
    assign rd_addr = (n_state == S_FLUSH) ? ADDR_W'(n_fidx)
                                          : ADDR_W'(CUR_W'(n_cursor - CUR_W'(1)));

    // Send the held result on; it is final when the item is done
    assign o_push.valid    = r_pend_valid && (emit || fin);
    assign o_push.res.act  = r_pend_act;
    assign o_push.res.data = r_pend_data;
    assign o_push.res.last = fin;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cursor       <= '0;
            r_fidx         <= '0;
            r_session_over <= 1'b0;
            r_pend_valid   <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_cursor       <= n_cursor;
            r_fidx         <= n_fidx;
            r_session_over <= n_session_over;
            if (emit) begin
                r_pend_valid <= 1'b1;
            end else if (fin) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid) begin
            r_byte <= i_in_byte;
        end
        if (emit) begin
            r_pend_act  <= emit_act;
            r_pend_data <= emit_data;
        end
    end

    tle_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_line_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (ADDR_W'(r_cursor)),
        .i_wr_data (r_byte),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

endmodule
`default_nettype wire

>>> design/tle_out.sv
// Output register stage between the sequencer and the result channel.
`default_nettype none
module tle_out import tle_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_push     i_push,
    output logic      o_ready,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output logic [2:0] o_action,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    logic    r_valid;
    t_result r_res;

    assign o_ready     = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_action    = r_res.act;
    assign o_out_byte  = r_res.data;
    assign o_last      = r_res.last;

    // Hold the item until taken, load when free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_res <= i_push.res;
        end
    end

endmodule
`default_nettype wire

>>> design/terminal_line_editor_core.sv
// Top level of the terminal line editor: configuration register and block wiring.
//
// Usage: keyboard bytes enter on the input channel (i_in_valid, i_in_byte,
// o_in_stall); terminal actions leave on the result channel (o_out_valid,
// o_action, o_out_byte, o_last, i_out_stall). An item moves at a clock edge
// with valid high and stall low, but no input byte is taken once the session
// has ended. One input byte gives zero or more result items; o_last marks the
// final one of each byte. The line limit is written through i_cfg_wr_en /
// i_cfg_wr_data; the user must write it only while idle, which the block
// itself does not enforce. Bytes are handled one at a time. Erases and
// flushes walk the line store at one entry per cycle, while the result side
// does not stall, through its single read port.
// Reset (i_rst_n low, synchronous) clears the cursor, the session flag and
// the output register, and sets the limit to 40; the line store is not
// cleared. A stall on the result side holds the sequencer in place with the
// pending result kept, and the input stays stalled until the byte is done.
`default_nettype none
module terminal_line_editor_core import tle_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [7:0]         i_in_byte,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [2:0]              o_action,
    output logic [7:0]              o_out_byte,
    output logic                    o_last,
    input  wire logic               i_cfg_wr_en,
    input  wire logic [LIMIT_W-1:0] i_cfg_wr_data
);

    logic [LIMIT_W-1:0] r_line_limit;
    logic               out_ready;
    t_push              push;

    // Line limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_line_limit <= i_cfg_wr_data;
        end
    end

    tle_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_byte    (i_in_byte),
        .i_line_limit (r_line_limit),
        .i_out_ready  (out_ready),
        .o_push       (push)
    );

    tle_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_ready     (out_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_action    (o_action),
        .o_out_byte  (o_out_byte),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire
